// ----- rtl/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types and constants of the HTTP request header parser.
// ----------------------------------------------------------------------------
`default_nettype none
package hrhp_pkg;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_PATH    = 4'd1,
    PH_ANAME   = 4'd2,
    PH_AVALUE  = 4'd3,
    PH_VERSION = 4'd4,
    PH_RLF     = 4'd5,
    PH_HNAME   = 4'd6,
    PH_HVSTART = 4'd7,
    PH_HVALUE  = 4'd8,
    PH_HLF     = 4'd9,
    PH_ENDLF   = 4'd10,
    PH_BODY    = 4'd11,
    PH_DONE    = 4'd12,
    PH_ERROR   = 4'd13
  } phase_t;

  typedef enum logic [2:0] {
    LS_NONE     = 3'd0,
    LS_OK       = 3'd1,
    LS_BAD      = 3'd2,
    LS_DONE_OK  = 3'd3,
    LS_DONE_BAD = 3'd4
  } len_state_t;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_LINEBRK  = 4'd1;
  localparam logic [3:0] ERR_TOOLONG  = 4'd2;
  localparam logic [3:0] ERR_VERSION  = 4'd3;
  localparam logic [3:0] ERR_NOLF     = 4'd4;
  localparam logic [3:0] ERR_EMPTYHDR = 4'd5;
  localparam logic [3:0] ERR_EARLYEND = 4'd6;
  localparam logic [3:0] ERR_BADPATH  = 4'd7;
  localparam logic [3:0] ERR_BADLEN   = 4'd8;

  localparam logic [2:0] TK_NONE   = 3'd0;
  localparam logic [2:0] TK_METHOD = 3'd1;
  localparam logic [2:0] TK_PATH   = 3'd2;
  localparam logic [2:0] TK_ANAME  = 3'd3;
  localparam logic [2:0] TK_AVALUE = 3'd4;
  localparam logic [2:0] TK_HNAME  = 3'd5;
  localparam logic [2:0] TK_HVALUE = 3'd6;
  localparam logic [2:0] TK_BODY   = 3'd7;

  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  localparam logic [1:0] MC_GET     = 2'd0;
  localparam logic [1:0] MC_PUT     = 2'd1;
  localparam logic [1:0] MC_POST    = 2'd2;
  localparam logic [1:0] MC_UNKNOWN = 2'd3;

  // classified input byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       eos;
    logic       is_sp;
    logic       is_break;
    logic       is_cr;
    logic       is_lf;
    logic       is_ver;
    logic       is_digit;
  } cls_t;

  // one result item
  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       token_end;
    logic [1:0] method_code;
    logic       length_header;
    logic [1:0] parse_status;
    logic [3:0] error_code;
  } result_t;

  // byte of "Content-Length" at a position, 0 past the end
  function automatic logic [7:0] clen_char(input logic [3:0] pos);
    case (pos)
      4'd0: clen_char = 8'h43;  4'd1: clen_char = 8'h6f;
      4'd2: clen_char = 8'h6e;  4'd3: clen_char = 8'h74;
      4'd4: clen_char = 8'h65;  4'd5: clen_char = 8'h6e;
      4'd6: clen_char = 8'h74;  4'd7: clen_char = 8'h2d;
      4'd8: clen_char = 8'h4c;  4'd9: clen_char = 8'h65;
      4'd10: clen_char = 8'h6e; 4'd11: clen_char = 8'h67;
      4'd12: clen_char = 8'h74; 4'd13: clen_char = 8'h68;
      default: clen_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hrhp_stream_if.sv -----
// ----------------------------------------------------------------------------
// hrhp_stream_if
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none
interface hrhp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/hrhp_front.sv -----
// ----------------------------------------------------------------------------
// hrhp_front
// Accepts request bytes, classifies them and pushes them into a short queue.
// ----------------------------------------------------------------------------
`default_nettype none
module hrhp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_end_of_stream,
  output      logic          q_valid,
  input  wire logic          q_ready,
  output      hrhp_pkg::cls_t q_data
);
  import hrhp_pkg::*;

  // two-entry queue
  cls_t       mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push, pop;
  cls_t       cls;
  logic [7:0] c;

  // byte classification
  always_comb begin
    c = in_data_byte;
    cls.data_byte = c;
    cls.eos       = in_end_of_stream;
    cls.is_sp     = (c == 8'h20);
    cls.is_cr     = (c == 8'h0d);
    cls.is_lf     = (c == 8'h0a);
    cls.is_break  = (c == 8'h0d) || (c == 8'h0a);
    cls.is_ver    = (c == 8'h48) || (c == 8'h54) || (c == 8'h50) || (c == 8'h2f) ||
                    (c == 8'h31) || (c == 8'h2e) || (c == 8'h30);
    cls.is_digit  = (c >= 8'h30) && (c <= 8'h39);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];
  assign cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("bad queue count");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ----- rtl/hrhp_back.sv -----
// ----------------------------------------------------------------------------
// hrhp_back
// Parse state machine: takes classified bytes and registers one result each.
// ----------------------------------------------------------------------------
`default_nettype none
module hrhp_back #(
  parameter int MAX_TOKEN   = 511,
  parameter int MAX_SEGMENT = 255
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output      logic            q_ready,
  input  wire hrhp_pkg::cls_t  q_data,
  input  wire logic            cfg_write,
  input  wire logic [23:0]     cfg_data,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      hrhp_pkg::result_t out_data
);
  import hrhp_pkg::*;

  localparam int TW = $clog2(MAX_TOKEN + 1);
  localparam int SW = $clog2(MAX_SEGMENT + 1);

  phase_t     phase_r, phase_nxt;
  logic [TW-1:0] tlen_r, tlen_nxt;
  logic [2:0] mm_r, mm_nxt;
  logic [SW-1:0] seg_r, seg_nxt;
  logic [1:0] pbad_r, pbad_nxt;
  logic       nm_r, nm_nxt;
  len_state_t ls_r, ls_nxt;
  logic [23:0] lv_r, lv_nxt;
  logic [23:0] br_r, br_nxt;
  logic [1:0] hm_r, hm_nxt;
  logic [3:0] he_r, he_nxt;
  logic [23:0] maxlen_r;
  logic       ov_r;
  result_t    res_r, res;
  logic       step;
  logic [28:0] lv_mul;
  logic [7:0] c;
  logic [7:0] exp_get, exp_put, exp_post;
  logic       tok_full;

  assign q_ready = !ov_r || out_ready;
  assign step    = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_data  = res_r;
  assign c = q_data.data_byte;
  assign tok_full = (tlen_r >= TW'(MAX_TOKEN));
  assign lv_mul = {5'd0, lv_r} * 29'd10 + {25'd0, c[3:0]};

  // method reference bytes by position
  always_comb begin
    exp_get = 8'h00; exp_put = 8'h00; exp_post = 8'h00;
    case (tlen_r)
      TW'(0): begin exp_get = 8'h47; exp_put = 8'h50; exp_post = 8'h50; end
      TW'(1): begin exp_get = 8'h45; exp_put = 8'h55; exp_post = 8'h4f; end
      TW'(2): begin exp_get = 8'h54; exp_put = 8'h54; exp_post = 8'h53; end
      TW'(3): exp_post = 8'h54;
      default: ;
    endcase
  end

  // next state and result
  always_comb begin
    phase_t     lsp;
    len_state_t lsb;
    logic [23:0] lvb;
    phase_nxt = phase_r; tlen_nxt = tlen_r; mm_nxt = mm_r; seg_nxt = seg_r;
    pbad_nxt = pbad_r; nm_nxt = nm_r; ls_nxt = ls_r; lv_nxt = lv_r;
    br_nxt = br_r; hm_nxt = hm_r; he_nxt = he_r;
    res = '0;
    lsp = PH_DONE;
    lsb = ls_r;
    lvb = lv_r;
    // digit accumulation of the length header
    if (ls_r == LS_OK) begin
      if (q_data.is_digit && lv_mul <= 29'h0ffffff) lvb = lv_mul[23:0];
      else lsb = LS_BAD;
    end
    // outcome of the blank line ending the headers
    if (pbad_r != 2'd0) lsp = PH_ERROR;
    else if (ls_r == LS_DONE_BAD || (ls_r == LS_DONE_OK && lv_r > maxlen_r)) lsp = PH_ERROR;
    else if (ls_r == LS_DONE_OK && lv_r != 24'd0) lsp = PH_BODY;

    if (phase_r == PH_DONE || phase_r == PH_ERROR) begin
    end else if (q_data.eos) begin
      phase_nxt = PH_ERROR; he_nxt = ERR_EARLYEND;
    end else begin
      case (phase_r)
        PH_METHOD: begin
          if (q_data.is_sp) begin
            res.token_kind = TK_METHOD; res.token_end = 1'b1;
            if (mm_r[0] && tlen_r == TW'(3)) hm_nxt = MC_GET;
            else if (mm_r[1] && tlen_r == TW'(3)) hm_nxt = MC_PUT;
            else if (mm_r[2] && tlen_r == TW'(4)) hm_nxt = MC_POST;
            else hm_nxt = MC_UNKNOWN;
            tlen_nxt = '0; seg_nxt = '0; pbad_nxt = 2'd0; phase_nxt = PH_PATH;
          end else if (q_data.is_break) begin
            phase_nxt = PH_ERROR; he_nxt = ERR_LINEBRK;
          end else if (!tok_full) begin
            res.token_kind = TK_METHOD; res.byte_valid = 1'b1;
            if (c != exp_get)  mm_nxt[0] = 1'b0;
            if (c != exp_put)  mm_nxt[1] = 1'b0;
            if (c != exp_post) mm_nxt[2] = 1'b0;
            tlen_nxt = tlen_r + TW'(1);
          end else begin
            phase_nxt = PH_ERROR; he_nxt = ERR_TOOLONG;
          end
        end
        PH_PATH: begin
          if (q_data.is_sp || c == 8'h3f) begin
            res.token_kind = TK_PATH; res.token_end = 1'b1; tlen_nxt = '0;
            phase_nxt = q_data.is_sp ? PH_VERSION : PH_ANAME;
          end else if (q_data.is_break) begin
            phase_nxt = PH_ERROR; he_nxt = ERR_LINEBRK;
          end else if (!tok_full) begin
            res.token_kind = TK_PATH; res.byte_valid = 1'b1;
            if (c == 8'h2f) seg_nxt = '0;
            else if (tlen_r == '0) pbad_nxt[0] = 1'b1;
            else if (seg_r >= SW'(MAX_SEGMENT)) pbad_nxt[1] = 1'b1;
            else seg_nxt = seg_r + SW'(1);
            tlen_nxt = tlen_r + TW'(1);
          end else begin
            phase_nxt = PH_ERROR; he_nxt = ERR_TOOLONG;
          end
        end
        PH_ANAME, PH_AVALUE: begin
          res.token_kind = (phase_r == PH_ANAME) ? TK_ANAME : TK_AVALUE;
          if (q_data.is_sp || c == 8'h26 || (c == 8'h3d && phase_r == PH_ANAME)) begin
            res.token_end = 1'b1; tlen_nxt = '0;
            if (q_data.is_sp) phase_nxt = PH_VERSION;
            else if (c == 8'h26) phase_nxt = PH_ANAME;
            else phase_nxt = PH_AVALUE;
          end else if (q_data.is_break) begin
            phase_nxt = PH_ERROR; he_nxt = ERR_LINEBRK;
          end else if (!tok_full) begin
            res.byte_valid = 1'b1; tlen_nxt = tlen_r + TW'(1);
          end else begin
            phase_nxt = PH_ERROR; he_nxt = ERR_TOOLONG;
          end
        end
        PH_VERSION: begin
          if (q_data.is_lf) begin
            tlen_nxt = '0; nm_nxt = 1'b1; phase_nxt = PH_HNAME;
          end else if (q_data.is_cr) phase_nxt = PH_RLF;
          else if (!q_data.is_ver) begin
            phase_nxt = PH_ERROR; he_nxt = ERR_VERSION;
          end
        end
        PH_RLF, PH_HLF: begin
          if (q_data.is_lf) begin
            tlen_nxt = '0; nm_nxt = 1'b1; phase_nxt = PH_HNAME;
          end else begin
            phase_nxt = PH_ERROR; he_nxt = ERR_NOLF;
          end
        end
        PH_HNAME: begin
          if (q_data.is_lf && tlen_r == '0) begin
            phase_nxt = lsp;
            if (lsp == PH_ERROR) he_nxt = (pbad_r != 2'd0) ? ERR_BADPATH : ERR_BADLEN;
            if (lsp == PH_BODY) br_nxt = lv_r;
          end else if (q_data.is_cr && tlen_r == '0) begin
            phase_nxt = PH_ENDLF;
          end else if (c == 8'h3a) begin
            res.token_kind = TK_HNAME; res.token_end = 1'b1;
            if (nm_r && tlen_r == TW'(14) && ls_r == LS_NONE) begin
              ls_nxt = LS_OK; lv_nxt = '0;
            end
            tlen_nxt = '0; phase_nxt = PH_HVSTART;
          end else if (!tok_full) begin
            res.token_kind = TK_HNAME; res.byte_valid = 1'b1;
            if (tlen_r >= TW'(14) || c != clen_char(tlen_r[3:0])) nm_nxt = 1'b0;
            tlen_nxt = tlen_r + TW'(1);
          end else begin
            phase_nxt = PH_ERROR; he_nxt = ERR_TOOLONG;
          end
        end
        PH_HVSTART: begin
          if (q_data.is_sp || c == 8'h09) begin
          end else if (q_data.is_break) begin
            phase_nxt = PH_ERROR; he_nxt = ERR_EMPTYHDR;
          end else begin
            res.token_kind = TK_HVALUE; res.byte_valid = 1'b1;
            ls_nxt = lsb; lv_nxt = lvb;
            res.length_header = (lsb == LS_OK || lsb == LS_BAD);
            tlen_nxt = TW'(1); phase_nxt = PH_HVALUE;
          end
        end
        PH_HVALUE: begin
          if (q_data.is_break) begin
            res.token_kind = TK_HVALUE; res.token_end = 1'b1;
            res.length_header = (ls_r == LS_OK || ls_r == LS_BAD);
            if (ls_r == LS_OK) ls_nxt = LS_DONE_OK;
            else if (ls_r == LS_BAD) ls_nxt = LS_DONE_BAD;
            tlen_nxt = '0;
            if (q_data.is_cr) phase_nxt = PH_HLF;
            else begin nm_nxt = 1'b1; phase_nxt = PH_HNAME; end
          end else if (!tok_full) begin
            res.token_kind = TK_HVALUE; res.byte_valid = 1'b1;
            ls_nxt = lsb; lv_nxt = lvb;
            res.length_header = (lsb == LS_OK || lsb == LS_BAD);
            tlen_nxt = tlen_r + TW'(1);
          end else begin
            phase_nxt = PH_ERROR; he_nxt = ERR_TOOLONG;
          end
        end
        PH_ENDLF: begin
          if (q_data.is_lf) begin
            phase_nxt = lsp;
            if (lsp == PH_ERROR) he_nxt = (pbad_r != 2'd0) ? ERR_BADPATH : ERR_BADLEN;
            if (lsp == PH_BODY) br_nxt = lv_r;
          end else begin
            phase_nxt = PH_ERROR; he_nxt = ERR_NOLF;
          end
        end
        PH_BODY: begin
          res.token_kind = TK_BODY; res.byte_valid = 1'b1;
          if (br_r != '0) br_nxt = br_r - 24'd1;
          if (br_r <= 24'd1) phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_ERROR; he_nxt = ERR_EARLYEND;
        end
      endcase
    end
    res.byte_out    = res.byte_valid ? c : 8'd0;
    res.method_code = hm_nxt;
    if (phase_nxt == PH_DONE) res.parse_status = ST_COMPLETE;
    else if (phase_nxt == PH_ERROR) begin
      res.parse_status = ST_REJECTED; res.error_code = he_nxt;
      res.token_kind = TK_NONE; res.byte_valid = 1'b0; res.byte_out = 8'd0;
      res.token_end = 1'b0; res.length_header = 1'b0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD; tlen_r <= '0; mm_r <= 3'b111; seg_r <= '0;
      pbad_r <= 2'd0; nm_r <= 1'b1; ls_r <= LS_NONE; lv_r <= '0; br_r <= '0;
      hm_r <= MC_UNKNOWN; he_r <= ERR_NONE; ov_r <= 1'b0;
      maxlen_r <= 24'd1048576;
    end else begin
      if (cfg_write) maxlen_r <= cfg_data;
      if (step) begin
        phase_r <= phase_nxt; tlen_r <= tlen_nxt; mm_r <= mm_nxt; seg_r <= seg_nxt;
        pbad_r <= pbad_nxt; nm_r <= nm_nxt; ls_r <= ls_nxt; lv_r <= lv_nxt;
        br_r <= br_nxt; hm_r <= hm_nxt; he_r <= he_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(res_r)) else $error("result lost");
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_DONE || phase_r == PH_ERROR) |=> $stable(phase_r))
    else $error("left final phase");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |-> he_r != ERR_NONE) else $error("error without code");
endmodule
`default_nettype wire

// ----- rtl/http_request_header_parser.sv -----
// ----------------------------------------------------------------------------
// http_request_header_parser
// Byte-wise HTTP/1.0 request parser with body pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: one request byte (or end-of-stream mark) per transaction.
//   out channel: exactly one result per input transaction, in order.
//   cfg port   : write max_content_length while idle; reset value 1048576.
// Throughput: one byte per cycle sustained while out_ready stays high; the parse
//   state machine in the back end updates once per byte.
// Path: an accepted byte is stored in the classification queue, and its result
//   is then registered in the output register, where it shows as valid.
// Reset: synchronous active-low rst_n; the parser returns to expecting the
//   method and all queues empty.
// Stall: when out_ready is low the result register holds; the two-entry
//   queue fills and then in_ready drops. No transaction is lost.
// After a request completes or is rejected the status repeats until reset.
// ----------------------------------------------------------------------------
`default_nettype none
module http_request_header_parser #(
  parameter int MAX_TOKEN   = 511,
  parameter int MAX_SEGMENT = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_stream,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [2:0]  out_token_kind,
  output      logic [7:0]  out_byte_out,
  output      logic        out_byte_valid,
  output      logic        out_token_end,
  output      logic [1:0]  out_method_code,
  output      logic        out_length_header,
  output      logic [1:0]  out_parse_status,
  output      logic [3:0]  out_error_code,
  input  wire logic        cfg_write,
  input  wire logic [23:0] cfg_data
);
  import hrhp_pkg::*;

  logic    q_valid, q_ready;
  cls_t    q_data;
  result_t res;

  // front: accept and classify
  hrhp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_end_of_stream,
    .q_valid, .q_ready, .q_data
  );

  // back: parse and register results
  hrhp_back #(.MAX_TOKEN(MAX_TOKEN), .MAX_SEGMENT(MAX_SEGMENT)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .cfg_write, .cfg_data,
    .out_valid, .out_ready, .out_data(res)
  );

  assign out_token_kind    = res.token_kind;
  assign out_byte_out      = res.byte_out;
  assign out_byte_valid    = res.byte_valid;
  assign out_token_end     = res.token_end;
  assign out_method_code   = res.method_code;
  assign out_length_header = res.length_header;
  assign out_parse_status  = res.parse_status;
  assign out_error_code    = res.error_code;
endmodule
`default_nettype wire

// ----- test/hrhp_result_checker.sv -----
// ----------------------------------------------------------------------------
// hrhp_result_checker
// Watches the byte and result channels of the request parser, predicts one
// result for every accepted byte and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hrhp_result_checker #(
  parameter int MAX_TOKEN   = 511,
  parameter int MAX_SEGMENT = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [8:0]        in_payload,
  input  logic              out_valid,
  input  logic              out_ready,
  input  hrhp_pkg::result_t out_payload,
  input  logic              cfg_write,
  input  logic [23:0]       cfg_data,
  output int                error_count,
  output int                pending_results
);
  import hrhp_pkg::*;

  localparam string METHOD_GET  = "GET";
  localparam string METHOD_PUT  = "PUT";
  localparam string METHOD_POST = "POST";
  localparam string VERSION_STR = "HTTP/1.0";
  localparam string CLEN_NAME   = "Content-Length";

  // parser model state
  logic [23:0] max_body_len;
  phase_t      phase;
  int unsigned tok_len;
  int unsigned seg_len;
  logic [2:0]  method_hits;
  logic [1:0]  path_fault;
  logic        clen_hit;
  len_state_t  clen_state;
  logic [23:0] clen_value;
  logic [23:0] body_left;
  logic [1:0]  last_method;
  logic [3:0]  reject_code;

  result_t expected_results[$];

  assign pending_results = expected_results.size();

  function automatic bit char_at(string s, int unsigned pos, logic [7:0] c);
    return pos < s.len() && s[pos] == c;
  endfunction

  function automatic bit is_crlf(logic [7:0] c);
    return c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic void reject(logic [3:0] code);
    phase = PH_ERROR;
    reject_code = code;
  endfunction

  function automatic void clen_digit(logic [7:0] c);
    logic [31:0] nv;
    if (clen_state != LS_OK) return;
    if (c >= "0" && c <= "9") begin
      nv = clen_value * 10 + (c - "0");
      if (nv > 32'hFFFFFF) clen_state = LS_BAD;
      else clen_value = nv[23:0];
    end else begin
      clen_state = LS_BAD;
    end
  endfunction

  function automatic void close_header();
    if (clen_state == LS_OK) clen_state = LS_DONE_OK;
    else if (clen_state == LS_BAD) clen_state = LS_DONE_BAD;
  endfunction

  function automatic void start_hname();
    tok_len = 0;
    clen_hit = 1'b1;
    phase = PH_HNAME;
  endfunction

  function automatic void finish_headers();
    if (path_fault != 0) begin
      reject(ERR_BADPATH);
      return;
    end
    if (clen_state == LS_DONE_BAD ||
        (clen_state == LS_DONE_OK && clen_value > max_body_len)) begin
      reject(ERR_BADLEN);
      return;
    end
    if (clen_state == LS_DONE_OK && clen_value != 0) begin
      body_left = clen_value;
      phase = PH_BODY;
    end else begin
      phase = PH_DONE;
    end
  endfunction

  // next parser result for one byte
  function automatic result_t parse_byte(logic [7:0] c, logic eos);
    result_t r;
    logic [2:0] kind;
    bit vld, tend, lenhdr, vok;
    kind = TK_NONE; vld = 0; tend = 0; lenhdr = 0;
    r = '0;
    if (phase == PH_DONE || phase == PH_ERROR) begin
    end else if (eos) begin
      reject(ERR_EARLYEND);
    end else begin
      case (phase)
        PH_METHOD: begin
          if (c == " ") begin
            kind = TK_METHOD; tend = 1;
            if (method_hits[0] && tok_len == 3) last_method = MC_GET;
            else if (method_hits[1] && tok_len == 3) last_method = MC_PUT;
            else if (method_hits[2] && tok_len == 4) last_method = MC_POST;
            else last_method = MC_UNKNOWN;
            tok_len = 0; seg_len = 0; path_fault = 0;
            phase = PH_PATH;
          end else if (is_crlf(c)) begin
            reject(ERR_LINEBRK);
          end else if (tok_len < MAX_TOKEN) begin
            kind = TK_METHOD; vld = 1;
            if (!char_at(METHOD_GET, tok_len, c)) method_hits[0] = 0;
            if (!char_at(METHOD_PUT, tok_len, c)) method_hits[1] = 0;
            if (!char_at(METHOD_POST, tok_len, c)) method_hits[2] = 0;
            tok_len++;
          end else begin
            reject(ERR_TOOLONG);
          end
        end
        PH_PATH: begin
          if (c == " " || c == "?") begin
            kind = TK_PATH; tend = 1;
            tok_len = 0;
            phase = (c == " ") ? PH_VERSION : PH_ANAME;
          end else if (is_crlf(c)) begin
            reject(ERR_LINEBRK);
          end else if (tok_len < MAX_TOKEN) begin
            kind = TK_PATH; vld = 1;
            if (c == "/") seg_len = 0;
            else if (tok_len == 0) path_fault[0] = 1;
            else if (seg_len >= MAX_SEGMENT) path_fault[1] = 1;
            else seg_len++;
            tok_len++;
          end else begin
            reject(ERR_TOOLONG);
          end
        end
        PH_ANAME, PH_AVALUE: begin
          kind = (phase == PH_ANAME) ? TK_ANAME : TK_AVALUE;
          if (c == " " || c == "&" || (c == "=" && phase == PH_ANAME)) begin
            tend = 1;
            tok_len = 0;
            if (c == " ") phase = PH_VERSION;
            else if (c == "&") phase = PH_ANAME;
            else phase = PH_AVALUE;
          end else if (is_crlf(c)) begin
            kind = TK_NONE;
            reject(ERR_LINEBRK);
          end else if (tok_len < MAX_TOKEN) begin
            vld = 1;
            tok_len++;
          end else begin
            kind = TK_NONE;
            reject(ERR_TOOLONG);
          end
        end
        PH_VERSION: begin
          if (c == 8'h0a) start_hname();
          else if (c == 8'h0d) phase = PH_RLF;
          else begin
            vok = 0;
            for (int i = 0; i < VERSION_STR.len(); i++)
              if (VERSION_STR[i] == c) vok = 1;
            if (!vok) reject(ERR_VERSION);
          end
        end
        PH_RLF, PH_HLF: begin
          if (c == 8'h0a) start_hname();
          else reject(ERR_NOLF);
        end
        PH_HNAME: begin
          if (c == 8'h0a && tok_len == 0) begin
            finish_headers();
          end else if (c == 8'h0d && tok_len == 0) begin
            phase = PH_ENDLF;
          end else if (c == ":") begin
            kind = TK_HNAME; tend = 1;
            if (clen_hit && tok_len == 14 && clen_state == LS_NONE) begin
              clen_state = LS_OK;
              clen_value = 0;
            end
            tok_len = 0;
            phase = PH_HVSTART;
          end else if (tok_len < MAX_TOKEN) begin
            kind = TK_HNAME; vld = 1;
            if (!char_at(CLEN_NAME, tok_len, c)) clen_hit = 0;
            tok_len++;
          end else begin
            reject(ERR_TOOLONG);
          end
        end
        PH_HVSTART: begin
          if (c == " " || c == 8'h09) begin
          end else if (is_crlf(c)) begin
            reject(ERR_EMPTYHDR);
          end else begin
            kind = TK_HVALUE; vld = 1;
            clen_digit(c);
            tok_len = 1;
            phase = PH_HVALUE;
          end
        end
        PH_HVALUE: begin
          if (is_crlf(c)) begin
            kind = TK_HVALUE; tend = 1;
            lenhdr = (clen_state == LS_OK || clen_state == LS_BAD);
            close_header();
            if (c == 8'h0d) begin
              tok_len = 0;
              phase = PH_HLF;
            end else begin
              start_hname();
            end
          end else if (tok_len < MAX_TOKEN) begin
            kind = TK_HVALUE; vld = 1;
            clen_digit(c);
            tok_len++;
          end else begin
            reject(ERR_TOOLONG);
          end
        end
        PH_ENDLF: begin
          if (c == 8'h0a) finish_headers();
          else reject(ERR_NOLF);
        end
        PH_BODY: begin
          kind = TK_BODY; vld = 1;
          if (body_left > 0) body_left--;
          if (body_left == 0) phase = PH_DONE;
        end
        default: reject(ERR_EARLYEND);
      endcase
    end

    if (kind == TK_HVALUE && vld && (clen_state == LS_OK || clen_state == LS_BAD))
      lenhdr = 1;
    r.parse_status = ST_BUSY;
    r.error_code   = ERR_NONE;
    if (phase == PH_DONE) begin
      r.parse_status = ST_COMPLETE;
    end else if (phase == PH_ERROR) begin
      r.parse_status = ST_REJECTED;
      r.error_code   = reject_code;
      kind = TK_NONE; vld = 0; tend = 0; lenhdr = 0;
    end
    r.token_kind    = kind;
    r.byte_out      = vld ? c : 8'h00;
    r.byte_valid    = vld;
    r.token_end     = tend;
    r.method_code   = last_method;
    r.length_header = lenhdr;
    return r;
  endfunction

  // compare results, then predict from the byte of this edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      max_body_len = 24'd1048576;
      phase = PH_METHOD;
      tok_len = 0; seg_len = 0;
      method_hits = 3'b111;
      path_fault = 0;
      clen_hit = 1'b1;
      clen_state = LS_NONE;
      clen_value = 0;
      body_left = 0;
      last_method = MC_UNKNOWN;
      reject_code = ERR_NONE;
      expected_results.delete();
      error_count = 0;
    end else begin
      if (cfg_write) max_body_len = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no byte outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_payload.token_kind != want.token_kind) begin
            $error("token_kind expected %0d got %0d", want.token_kind,
                   out_payload.token_kind);
            error_count++;
          end
          if (out_payload.byte_out != want.byte_out) begin
            $error("byte_out expected %0h got %0h", want.byte_out,
                   out_payload.byte_out);
            error_count++;
          end
          if (out_payload.byte_valid != want.byte_valid) begin
            $error("byte_valid expected %0d got %0d", want.byte_valid,
                   out_payload.byte_valid);
            error_count++;
          end
          if (out_payload.token_end != want.token_end) begin
            $error("token_end expected %0d got %0d", want.token_end,
                   out_payload.token_end);
            error_count++;
          end
          if (out_payload.method_code != want.method_code) begin
            $error("method_code expected %0d got %0d", want.method_code,
                   out_payload.method_code);
            error_count++;
          end
          if (out_payload.length_header != want.length_header) begin
            $error("length_header expected %0d got %0d", want.length_header,
                   out_payload.length_header);
            error_count++;
          end
          if (out_payload.parse_status != want.parse_status) begin
            $error("parse_status expected %0d got %0d", want.parse_status,
                   out_payload.parse_status);
            error_count++;
          end
          if (out_payload.error_code != want.error_code) begin
            $error("error_code expected %0d got %0d", want.error_code,
                   out_payload.error_code);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(parse_byte(in_payload[7:0], in_payload[8]));
    end
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams one long randomized HTTP/1.0 request (request line, optional query args,
// many headers, a Content-Length header and a body) through the parser with
// random stalls on both channels and updates the body limit between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import hrhp_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_write = 1'b0;
  logic [23:0] cfg_data = '0;
  logic        calm = 1'b0;
  int          error_count;
  int          pending_results;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          bytes_sent = 0;
  int          body_len;
  logic [23:0] final_limit;
  logic [7:0]  request_bytes[$];

  hrhp_stream_if #(.T(logic [8:0])) in_ch ();
  hrhp_stream_if #(.T(result_t))    out_ch ();

  http_request_header_parser u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.payload[7:0]),
    .in_end_of_stream (in_ch.payload[8]),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_token_kind   (out_ch.payload.token_kind),
    .out_byte_out     (out_ch.payload.byte_out),
    .out_byte_valid   (out_ch.payload.byte_valid),
    .out_token_end    (out_ch.payload.token_end),
    .out_method_code  (out_ch.payload.method_code),
    .out_length_header(out_ch.payload.length_header),
    .out_parse_status (out_ch.payload.parse_status),
    .out_error_code   (out_ch.payload.error_code),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data)
  );

  hrhp_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_payload     (in_ch.payload),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_payload    (out_ch.payload),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    out_ch.ready  <= 1'b0;
  end

  // result side backpressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(1, 15) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // random byte avoiding up to four delimiters
  function automatic logic [7:0] pick_byte(logic [7:0] x0, logic [7:0] x1,
                                           logic [7:0] x2, logic [7:0] x3);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == x0 || b == x1 || b == x2 || b == x3);
    return b;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endfunction

  function automatic void push_line_end();
    if ($urandom_range(0, 1)) request_bytes.push_back(8'h0d);
    request_bytes.push_back(8'h0a);
  endfunction

  function automatic void build_request_line();
    int n;
    case ($urandom_range(0, 3))
      0: push_text("GET");
      1: push_text("PUT");
      2: push_text("POST");
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) request_bytes.push_back(pick_byte(" ", 8'h0d, 8'h0a, 8'h0d));
      end
    endcase
    request_bytes.push_back(" ");
    // path segments, one of them sometimes at the segment limit
    n = $urandom_range(1, 4);
    for (int s = 0; s < n; s++) begin
      int seg;
      request_bytes.push_back("/");
      seg = (s == 0 && $urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 12);
      repeat (seg) request_bytes.push_back(pick_byte(" ", "?", 8'h0d, 8'h0a));
    end
    if ($urandom_range(0, 2) != 0) begin
      request_bytes.push_back("?");
      n = $urandom_range(1, 3);
      for (int a = 0; a < n; a++) begin
        if (a > 0) request_bytes.push_back("&");
        repeat ($urandom_range(0, 6))
          request_bytes.push_back(pick_byte(" ", "&", "=", 8'h0d));
        request_bytes.push_back("=");
        repeat ($urandom_range(0, 8))
          request_bytes.push_back(pick_byte(" ", "&", 8'h0d, 8'h0a));
      end
    end
    request_bytes.push_back(" ");
  endfunction

  function automatic void build_headers(int count);
    for (int h = 0; h < count; h++) begin
      request_bytes.push_back(pick_byte(":", 8'h0d, 8'h0a, ":"));
      repeat ($urandom_range(0, 14))
        request_bytes.push_back(pick_byte(":", ":", ":", ":"));
      request_bytes.push_back(":");
      repeat ($urandom_range(0, 2)) request_bytes.push_back($urandom_range(0, 1) ? " " : 8'h09);
      request_bytes.push_back(pick_byte(" ", 8'h09, 8'h0d, 8'h0a));
      repeat ($urandom_range(0, 28))
        request_bytes.push_back(pick_byte(8'h0d, 8'h0a, 8'h0d, 8'h0a));
      push_line_end();
    end
  endfunction

  // pushes the Content-Length header and returns nothing; length in body_len
  function automatic void build_length_header();
    string digits;
    digits = $sformatf("%0d", body_len);
    push_text("Content-Length:");
    if ($urandom_range(0, 1)) request_bytes.push_back(" ");
    repeat ($urandom_range(0, 2)) request_bytes.push_back("0");
    push_text(digits);
    push_line_end();
  endfunction

  task automatic send_queued();
    int gap;
    while (request_bytes.size() > 0) begin
      in_ch.valid   <= 1'b1;
      in_ch.payload <= {1'b0, request_bytes.pop_front()};
      do @(posedge clk); while (!in_ch.ready);
      bytes_sent++;
      if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_end_mark();
    in_ch.valid   <= 1'b1;
    in_ch.payload <= {1'b1, 8'($urandom_range(0, 255))};
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
  endtask

  // register written only with nothing in flight
  task automatic write_limit(logic [23:0] value);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int wait_cycles;
    bit early_end;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    body_len  = $urandom_range(680, 880);
    early_end = ($urandom_range(0, 3) == 0);

    write_limit(24'd0);
    build_request_line();
    push_text("HTTP/1.0");
    push_line_end();
    send_queued();

    write_limit(24'hFFFFFF);
    build_headers($urandom_range(4, 10));
    build_length_header();
    build_headers($urandom_range(2, 6));
    send_queued();

    write_limit(24'($urandom_range(0, 1000)));
    // a second length header is an ordinary header
    push_text("Content-Length: x9");
    push_line_end();
    build_headers($urandom_range(4, 10));
    send_queued();

    // final limit mostly admits the body, sometimes one short
    final_limit = ($urandom_range(0, 7) == 0) ? 24'(body_len - 1)
                : 24'($urandom_range(body_len, 24'hFFFFFF));
    write_limit(final_limit);
    push_line_end();
    for (int i = 0; i < body_len - (early_end ? 40 : 0); i++)
      request_bytes.push_back(8'($urandom_range(0, 255)));
    send_queued();
    calm <= 1'b1;
    if (early_end) send_end_mark();
    repeat (30) request_bytes.push_back(8'($urandom_range(0, 255)));
    send_queued();
    send_end_mark();

    wait_cycles = 0;
    while (pending_results != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);

    $display("request of %0d transactions, body %0d bytes, limit %0d, early end %0d",
             bytes_sent, body_len, final_limit, early_end);
    if (error_count == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- http_request_header_parser.f -----
rtl/hrhp_pkg.sv
rtl/hrhp_stream_if.sv
rtl/hrhp_front.sv
rtl/hrhp_back.sv
rtl/http_request_header_parser.sv
test/hrhp_result_checker.sv
test/testbench.sv
